// File: hdl/fbc_pkg.sv
// Shared types, constants and the CRC-16/MODBUS byte update for the frame builder.
// No dependencies; used by fbc_ctrl, fbc_outreg and frame_builder_crc16_unit.
package fbc_pkg;

    localparam int unsigned MAX_DATA_DEFAULT = 256;
    localparam logic [15:0] FRAME_LIMIT_RESET = 16'hFFFF;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    localparam logic [7:0] SYNC0_BYTE = 8'hAA;
    localparam logic [7:0] SYNC1_BYTE = 8'hBB;
    localparam logic [7:0] TAIL0_BYTE = 8'hCC;
    localparam logic [7:0] TAIL1_BYTE = 8'hDD;

    // Header and trailer bytes added around the data bytes
    localparam logic [16:0] FRAME_OVERHEAD   = 17'd10;
    localparam logic [15:0] PAYLOAD_OVERHEAD = 16'd4;

    // Input action codes
    localparam logic ACT_BEGIN = 1'b0;
    localparam logic ACT_DATA  = 1'b1;

    // Byte positions within one item's output sequence
    localparam logic [3:0] STEP_SYNC0 = 4'd0;
    localparam logic [3:0] STEP_SYNC1 = 4'd1;
    localparam logic [3:0] STEP_LENH  = 4'd2;
    localparam logic [3:0] STEP_LENL  = 4'd3;
    localparam logic [3:0] STEP_ADDR  = 4'd4;
    localparam logic [3:0] STEP_CMD   = 4'd5;
    localparam logic [3:0] STEP_CRCH  = 4'd6;
    localparam logic [3:0] STEP_CRCL  = 4'd7;
    localparam logic [3:0] STEP_TAIL0 = 4'd8;
    localparam logic [3:0] STEP_TAIL1 = 4'd9;
    localparam logic [3:0] STEP_DATA  = 4'd10;
    // Offset mapping a data item's trailer steps onto the begin numbering
    localparam logic [3:0] DATA_TRAIL_OFFSET = 4'd5;

    typedef struct packed {
        logic [7:0]  data;
        logic        last;
        logic        rej;
        logic [15:0] len;
    } result_t;

    function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in, input logic [7:0] b);
        logic [15:0] c;
        c = crc_in ^ {8'h00, b};
        for (int i = 0; i < 8; i++)
        begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

// File: hdl/fbc_ctrl.sv
// Item register, byte sequencer and frame state (open flag, bytes left, CRC, length).
// Depends on fbc_pkg.
module fbc_ctrl #(
    parameter int unsigned MAX_DATA = fbc_pkg::MAX_DATA_DEFAULT
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  logic             action,
    input  logic [7:0]       frame_address,
    input  logic [7:0]       command_code,
    input  logic [15:0]      data_length,
    input  logic [7:0]       data_byte,
    input  logic [15:0]      frame_limit,
    input  logic             out_free,
    output logic             res_valid,
    output fbc_pkg::result_t res
);

    logic        item_valid_reg, item_valid_next;
    logic        item_action_reg;
    logic [7:0]  addr_reg;
    logic [7:0]  cmd_reg;
    logic [15:0] dlen_reg;
    logic [7:0]  db_reg;
    logic [3:0]  seq_reg, seq_next;
    logic        frame_open_reg, frame_open_next;
    logic [15:0] bytes_left_reg, bytes_left_next;
    logic [15:0] crc_reg, crc_next;
    logic [15:0] total_len_reg, total_len_next;

    logic        is_begin;
    logic [16:0] flen;
    logic [15:0] plen;
    logic        too_long;
    logic        skip;
    logic [3:0]  idx;
    logic        last;
    logic        emit;
    logic        item_done;
    logic        accept;
    logic [7:0]  byte_sel;

    assign is_begin = (item_action_reg == fbc_pkg::ACT_BEGIN);
    assign flen     = {1'b0, dlen_reg} + fbc_pkg::FRAME_OVERHEAD;
    assign plen     = dlen_reg + fbc_pkg::PAYLOAD_OVERHEAD;
    assign too_long = (dlen_reg > 16'(MAX_DATA)) || (flen > {1'b0, frame_limit});

    // Data word with no frame open: drop it without output
    assign skip = !is_begin && (seq_reg == fbc_pkg::STEP_SYNC0)
                  && (!frame_open_reg || (bytes_left_reg == 16'd0));

    assign idx = is_begin ? seq_reg
               : ((seq_reg == 4'd0) ? fbc_pkg::STEP_DATA
                                    : seq_reg + fbc_pkg::DATA_TRAIL_OFFSET);

    always_comb
    begin
        if (is_begin)
        begin
            if (too_long)
                last = 1'b1;
            else if (dlen_reg == 16'd0)
                last = (idx == fbc_pkg::STEP_TAIL1);
            else
                last = (idx == fbc_pkg::STEP_CMD);
        end
        else
        begin
            if (seq_reg == 4'd0)
                last = (bytes_left_reg != 16'd1);
            else
                last = (idx == fbc_pkg::STEP_TAIL1);
        end
    end

    assign emit      = item_valid_reg && !skip && out_free;
    assign item_done = item_valid_reg && (skip || (emit && last));
    assign in_stall  = item_valid_reg && !item_done;
    assign accept    = in_valid && !in_stall;

    always_comb
    begin
        unique case (idx)
            fbc_pkg::STEP_SYNC0: byte_sel = fbc_pkg::SYNC0_BYTE;
            fbc_pkg::STEP_SYNC1: byte_sel = fbc_pkg::SYNC1_BYTE;
            fbc_pkg::STEP_LENH:  byte_sel = plen[15:8];
            fbc_pkg::STEP_LENL:  byte_sel = plen[7:0];
            fbc_pkg::STEP_ADDR:  byte_sel = addr_reg;
            fbc_pkg::STEP_CMD:   byte_sel = cmd_reg;
            fbc_pkg::STEP_CRCH:  byte_sel = crc_reg[15:8];
            fbc_pkg::STEP_CRCL:  byte_sel = crc_reg[7:0];
            fbc_pkg::STEP_TAIL0: byte_sel = fbc_pkg::TAIL0_BYTE;
            fbc_pkg::STEP_TAIL1: byte_sel = fbc_pkg::TAIL1_BYTE;
            fbc_pkg::STEP_DATA:  byte_sel = db_reg;
            default:             byte_sel = 8'h00;
        endcase
    end

    always_comb
    begin
        res_valid = emit;
        if (is_begin && too_long)
        begin
            res.data = 8'h00;
            res.last = 1'b1;
            res.rej  = 1'b1;
            res.len  = 16'd0;
        end
        else
        begin
            res.data = byte_sel;
            res.last = (idx == fbc_pkg::STEP_TAIL1);
            res.rej  = 1'b0;
            res.len  = is_begin ? flen[15:0] : total_len_reg;
        end
    end

    // Frame state advances as each byte goes out
    always_comb
    begin
        frame_open_next = frame_open_reg;
        bytes_left_next = bytes_left_reg;
        crc_next        = crc_reg;
        total_len_next  = total_len_reg;
        if (emit)
        begin
            if (is_begin && too_long)
            begin
                frame_open_next = 1'b0;
                bytes_left_next = 16'd0;
            end
            else
            begin
                priority if (idx == fbc_pkg::STEP_SYNC0)
                begin
                    total_len_next  = flen[15:0];
                    frame_open_next = (dlen_reg != 16'd0);
                    bytes_left_next = dlen_reg;
                end
                else if (idx == fbc_pkg::STEP_ADDR)
                    crc_next = fbc_pkg::crc16_byte(fbc_pkg::CRC_INIT, addr_reg);
                else if (idx == fbc_pkg::STEP_CMD)
                    crc_next = fbc_pkg::crc16_byte(crc_reg, cmd_reg);
                else if (idx == fbc_pkg::STEP_DATA)
                begin
                    crc_next        = fbc_pkg::crc16_byte(crc_reg, db_reg);
                    bytes_left_next = bytes_left_reg - 16'd1;
                end
                else if (idx == fbc_pkg::STEP_TAIL1)
                begin
                    frame_open_next = 1'b0;
                    bytes_left_next = 16'd0;
                end
                else
                begin
                    frame_open_next = frame_open_reg;
                end
            end
        end
    end

    always_comb
    begin
        item_valid_next = item_valid_reg;
        seq_next        = seq_reg;
        if (accept)
        begin
            item_valid_next = 1'b1;
            seq_next        = 4'd0;
        end
        else if (item_done)
            item_valid_next = 1'b0;
        else if (emit)
            seq_next = seq_reg + 4'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            seq_reg        <= 4'd0;
            frame_open_reg <= 1'b0;
            bytes_left_reg <= 16'd0;
            crc_reg        <= fbc_pkg::CRC_INIT;
            total_len_reg  <= 16'd0;
        end
        else
        begin
            item_valid_reg <= item_valid_next;
            seq_reg        <= seq_next;
            frame_open_reg <= frame_open_next;
            bytes_left_reg <= bytes_left_next;
            crc_reg        <= crc_next;
            total_len_reg  <= total_len_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_action_reg <= action;
            addr_reg        <= frame_address;
            cmd_reg         <= command_code;
            dlen_reg        <= data_length;
            db_reg          <= data_byte;
        end
    end

endmodule

// File: hdl/fbc_outreg.sv
// Output word register: holds one result word until the receiver takes it.
// Depends on fbc_pkg.
module fbc_outreg (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             res_valid,
    input  fbc_pkg::result_t res,
    output logic             out_free,
    output logic             out_valid,
    input  logic             out_stall,
    output logic [7:0]       out_byte,
    output logic             frame_end,
    output logic             rejected,
    output logic [15:0]      frame_length
);

    logic             valid_reg, valid_next;
    fbc_pkg::result_t word_reg;

    assign out_free = !valid_reg || !out_stall;

    always_comb
    begin
        if (res_valid)
            valid_next = 1'b1;
        else if (out_stall)
            valid_next = valid_reg;
        else
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    // Load only when the slot is free so a stalled word holds
    always_ff @(posedge clk)
    begin
        if (res_valid)
            word_reg <= res;
    end

    assign out_valid    = valid_reg;
    assign out_byte     = word_reg.data;
    assign frame_end    = word_reg.last;
    assign rejected     = word_reg.rej;
    assign frame_length = word_reg.len;

endmodule

// File: hdl/frame_builder_crc16_unit.sv
// Top level of the transmit frame builder with CRC-16/MODBUS.
// Depends on fbc_pkg, fbc_ctrl and fbc_outreg.
//
// Usage:
//   Input channel (in_valid / in_stall): a begin word (action 0) carries
//   address, command and data length; data words (action 1) carry one byte.
//   Output channel (out_valid / out_stall): one frame byte per word:
//   AA BB, length high/low, address, command, data..., CRC high/low, CC DD.
//   frame_end marks the DD byte; an oversize begin gives a single word with
//   rejected and frame_end set, and the frame's data words are dropped.
//   frame_limit is written through frame_limit_we / frame_limit_wdata while idle.
// Timing:
//   A word enters the item register, then its bytes are sequenced one a cycle,
//   unless the output is stalled, into the output register that offers them.
//   A data word in an open frame gives one byte, so data streams at one byte
//   per cycle while out_stall is low; a begin word gives 6 bytes (10 with zero
//   length), the last data word 5 (its byte, CRC and tail); a rejected begin one.
//   Data words with no frame open are dropped with no output.
// Reset: clears the frame state, CRC to FFFF, frame_limit to 65535.
// Stall: a stalled output word holds; the sequencer waits and in_stall rises.
module frame_builder_crc16_unit #(
    parameter int unsigned MAX_DATA = fbc_pkg::MAX_DATA_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        frame_limit_we,
    input  logic [15:0] frame_limit_wdata,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        action,
    input  logic [7:0]  frame_address,
    input  logic [7:0]  command_code,
    input  logic [15:0] data_length,
    input  logic [7:0]  data_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  out_byte,
    output logic        frame_end,
    output logic        rejected,
    output logic [15:0] frame_length
);

    logic [15:0]      frame_limit_reg;
    logic             res_valid;
    fbc_pkg::result_t res;
    logic             out_free;

    // Hold the configured limit; write only while idle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            frame_limit_reg <= fbc_pkg::FRAME_LIMIT_RESET;
        else if (frame_limit_we)
            frame_limit_reg <= frame_limit_wdata;
    end

    // Sequence each word into frame bytes and keep the frame state
    fbc_ctrl #(
        .MAX_DATA(MAX_DATA)
    ) u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .action        (action),
        .frame_address (frame_address),
        .command_code  (command_code),
        .data_length   (data_length),
        .data_byte     (data_byte),
        .frame_limit   (frame_limit_reg),
        .out_free      (out_free),
        .res_valid     (res_valid),
        .res           (res)
    );

    // Hold each result word for the receiver
    fbc_outreg u_outreg (
        .clk          (clk),
        .rst_n        (rst_n),
        .res_valid    (res_valid),
        .res          (res),
        .out_free     (out_free),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .out_byte     (out_byte),
        .frame_end    (frame_end),
        .rejected     (rejected),
        .frame_length (frame_length)
    );

    // A new byte is only produced when the output slot can take it
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> out_free)
        else $error("result word produced while output slot busy");

    // A rejection word always closes the frame and carries no length
    a_reject_form: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && rejected) |-> (frame_end && (frame_length == 16'd0)
                                     && (out_byte == 8'h00)))
        else $error("malformed rejection word");

    // After an accepted word, the input stalls, no byte is produced, or the output slot is free
    a_stall_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall || !res_valid || out_free)
        else $error("input accepted with sequencer blocked");

    // Limit register takes the written value
    a_limit_write: assert property (@(posedge clk) disable iff (!rst_n)
        frame_limit_we |=> (frame_limit_reg == $past(frame_limit_wdata)))
        else $error("frame limit write lost");

endmodule

// File: dv/frame_builder_crc16_unit_test.sv
// Self-checking testbench for frame_builder_crc16_unit: directed frames, length
// rejections, frame_limit edges and random frame traffic with and without random idling.
// Depends on fbc_pkg and frame_builder_crc16_unit.
`timescale 1ns / 100ps

module frame_builder_crc16_unit_test;

    localparam int unsigned MAX_DATA    = fbc_pkg::MAX_DATA_DEFAULT;
    // Watchdog bound for the whole run, set with a wide margin
    localparam int unsigned CYCLE_LIMIT = 400000;
    // A begin word with zero length keeps the sequencer busy for ten output bytes
    localparam int unsigned SETTLE_CYCLES = 16;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        frame_limit_we = 1'b0;
    logic [15:0] frame_limit_wdata = 16'h0000;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic        action = fbc_pkg::ACT_BEGIN;
    logic [7:0]  frame_address = 8'h00;
    logic [7:0]  command_code = 8'h00;
    logic [15:0] data_length = 16'h0000;
    logic [7:0]  data_byte = 8'h00;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [7:0]  out_byte;
    logic        frame_end;
    logic        rejected;
    logic [15:0] frame_length;

    // Idle odds in percent for the sender and the receiver
    int unsigned send_idle_pct = 27;
    int unsigned recv_idle_pct = 77;
    int unsigned cycle_count = 0;
    int unsigned error_count = 0;

    // Shadow of the frame builder state
    logic [15:0] tx_limit = fbc_pkg::FRAME_LIMIT_RESET;
    logic        tx_open = 1'b0;
    logic [15:0] tx_left = 16'h0000;
    logic [15:0] tx_crc = fbc_pkg::CRC_INIT;
    logic [15:0] tx_total = 16'h0000;

    // Frame bytes still owed by the block, oldest first
    fbc_pkg::result_t pending_bytes[$];
    fbc_pkg::result_t oldest;

    frame_builder_crc16_unit dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .frame_limit_we    (frame_limit_we),
        .frame_limit_wdata (frame_limit_wdata),
        .in_valid          (in_valid),
        .in_stall          (in_stall),
        .action            (action),
        .frame_address     (frame_address),
        .command_code      (command_code),
        .data_length       (data_length),
        .data_byte         (data_byte),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .out_byte          (out_byte),
        .frame_end         (frame_end),
        .rejected          (rejected),
        .frame_length      (frame_length)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Guard against a hung block or bytes that never arrive
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // Receiver back-pressure: stall at random with the current odds
    always @(posedge clk)
    begin
        out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end

    // CRC-16/MODBUS, one input bit at a time, LSB first
    function automatic logic [15:0] crc_modbus_step(input logic [15:0] crc,
                                                    input logic [7:0] b);
        logic [15:0] c;
        logic        fb;
        c = crc;
        for (int k = 0; k < 8; k++)
        begin
            fb = c[0] ^ b[k];
            c  = c >> 1;
            if (fb)
                c = c ^ fbc_pkg::CRC_POLY;
        end
        return c;
    endfunction

    task automatic push_byte(input logic [7:0] b, input logic last, input logic rej,
                             input logic [15:0] len);
        fbc_pkg::result_t r;
        begin
            r.data = b;
            r.last = last;
            r.rej  = rej;
            r.len  = len;
            pending_bytes.push_back(r);
        end
    endtask

    // Append CRC high, CRC low and the CC DD trailer, then close the frame
    task automatic close_frame;
        begin
            push_byte(tx_crc[15:8], 1'b0, 1'b0, tx_total);
            push_byte(tx_crc[7:0], 1'b0, 1'b0, tx_total);
            push_byte(fbc_pkg::TAIL0_BYTE, 1'b0, 1'b0, tx_total);
            push_byte(fbc_pkg::TAIL1_BYTE, 1'b1, 1'b0, tx_total);
            tx_open = 1'b0;
            tx_left = 16'h0000;
        end
    endtask

    // Work out the frame bytes that one accepted input word produces
    task automatic predict_frame_bytes(input logic act, input logic [7:0] addr,
                                       input logic [7:0] cmd, input logic [15:0] dlen,
                                       input logic [7:0] db);
        logic [16:0] full_len;
        logic [15:0] pay_len;
        begin
            if (act == fbc_pkg::ACT_BEGIN)
            begin
                full_len = {1'b0, dlen} + fbc_pkg::FRAME_OVERHEAD;
                pay_len  = dlen + fbc_pkg::PAYLOAD_OVERHEAD;
                if (dlen > MAX_DATA || full_len > {1'b0, tx_limit})
                begin
                    tx_open = 1'b0;
                    tx_left = 16'h0000;
                    push_byte(8'h00, 1'b1, 1'b1, 16'h0000);
                end
                else
                begin
                    tx_total = full_len[15:0];
                    tx_crc   = crc_modbus_step(crc_modbus_step(fbc_pkg::CRC_INIT, addr), cmd);
                    push_byte(fbc_pkg::SYNC0_BYTE, 1'b0, 1'b0, tx_total);
                    push_byte(fbc_pkg::SYNC1_BYTE, 1'b0, 1'b0, tx_total);
                    push_byte(pay_len[15:8], 1'b0, 1'b0, tx_total);
                    push_byte(pay_len[7:0], 1'b0, 1'b0, tx_total);
                    push_byte(addr, 1'b0, 1'b0, tx_total);
                    push_byte(cmd, 1'b0, 1'b0, tx_total);
                    if (dlen == 16'h0000)
                        close_frame();
                    else
                    begin
                        tx_open = 1'b1;
                        tx_left = dlen;
                    end
                end
            end
            else if (tx_open && tx_left != 16'h0000)
            begin
                tx_crc = crc_modbus_step(tx_crc, db);
                push_byte(db, 1'b0, 1'b0, tx_total);
                tx_left = tx_left - 16'd1;
                if (tx_left == 16'h0000)
                    close_frame();
            end
        end
    endtask

    // Compare every accepted output word with the oldest owed byte
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_bytes.size() == 0)
            begin
                $error("unexpected output word: out_byte %h frame_end %b rejected %b",
                       out_byte, frame_end, rejected);
                error_count++;
            end
            else
            begin
                oldest = pending_bytes.pop_front();
                if (out_byte !== oldest.data)
                begin
                    $error("out_byte: expected %h, got %h", oldest.data, out_byte);
                    error_count++;
                end
                if (frame_end !== oldest.last)
                begin
                    $error("frame_end: expected %b, got %b", oldest.last, frame_end);
                    error_count++;
                end
                if (rejected !== oldest.rej)
                begin
                    $error("rejected: expected %b, got %b", oldest.rej, rejected);
                    error_count++;
                end
                if (frame_length !== oldest.len)
                begin
                    $error("frame_length: expected %0d, got %0d", oldest.len, frame_length);
                    error_count++;
                end
            end
        end
    end

    // Offer one input word after a random gap, hold it until accepted, then predict
    task automatic send_word(input logic act, input logic [7:0] addr, input logic [7:0] cmd,
                             input logic [15:0] dlen, input logic [7:0] db);
        begin
            while ($urandom_range(0, 99) < send_idle_pct)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
            in_valid      <= 1'b1;
            action        <= act;
            frame_address <= addr;
            command_code  <= cmd;
            data_length   <= dlen;
            data_byte     <= db;
            @(posedge clk);
            while (in_stall)
                @(posedge clk);
            predict_frame_bytes(act, addr, cmd, dlen, db);
        end
    endtask

    // Unused fields of each word carry random values
    task automatic send_begin(input logic [7:0] addr, input logic [7:0] cmd,
                              input logic [15:0] dlen);
        begin
            send_word(fbc_pkg::ACT_BEGIN, addr, cmd, dlen, 8'($urandom_range(0, 255)));
        end
    endtask

    task automatic send_data(input logic [7:0] db);
        begin
            send_word(fbc_pkg::ACT_DATA, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                      16'($urandom_range(0, 65535)), db);
        end
    endtask

    // Drop valid and wait until every owed byte is out and the sequencer has settled
    task automatic wait_drain;
        begin
            in_valid <= 1'b0;
            while (pending_bytes.size() != 0)
                @(posedge clk);
            repeat (SETTLE_CYCLES) @(posedge clk);
        end
    endtask

    task automatic write_limit(input logic [15:0] value);
        begin
            wait_drain();
            frame_limit_we    <= 1'b1;
            frame_limit_wdata <= value;
            @(posedge clk);
            frame_limit_we <= 1'b0;
            tx_limit = value;
        end
    endtask

    // Zero-length frame, a single data byte, and a stray data word with no frame open
    task automatic test_zero_and_single_byte;
        begin
            send_begin(8'h00, 8'h00, 16'd0);
            send_begin(8'hFF, 8'hFF, 16'd1);
            send_data(8'hFF);
            send_data(8'h5A);
        end
    endtask

    // Lengths past MAX_DATA are refused; a refusal closes an open frame
    task automatic test_oversize_lengths;
        begin
            send_begin(8'h81, 8'h7E, 16'(MAX_DATA + 1));
            send_begin(8'h3C, 8'hC3, 16'hFFFF);
            send_data(8'h11);
            send_begin(8'h01, 8'h02, 16'd3);
            send_data(8'hA5);
            send_begin(8'h10, 8'h20, 16'd300);
            send_data(8'h77);
        end
    endtask

    // A begin while a frame is open abandons it without a trailer
    task automatic test_abandoned_frames;
        begin
            send_begin(8'h5A, 8'hA5, 16'(MAX_DATA));
            send_data(8'h00);
            send_data(8'hFF);
            send_begin(8'h12, 8'h34, 16'd2);
            send_data(8'h80);
            send_data(8'h01);
        end
    endtask

    // frame_limit boundaries: exact fit, one over, and everything refused
    task automatic test_frame_limit_edges;
        begin
            write_limit(16'd10);
            send_begin(8'hF0, 8'h0F, 16'd0);
            send_begin(8'hF0, 8'h0F, 16'd1);
            write_limit(16'd11);
            send_begin(8'hAA, 8'h55, 16'd1);
            send_data(8'hC4);
            write_limit(16'd0);
            send_begin(8'h00, 8'hFF, 16'd0);
            write_limit(16'hFFFF);
        end
    endtask

    // One full MAX_DATA frame that exactly meets the limit
    task automatic test_longest_frame;
        begin
            write_limit(16'(MAX_DATA + 10));
            send_begin(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 16'(MAX_DATA));
            repeat (MAX_DATA) send_data(8'($urandom_range(0, 255)));
        end
    endtask

    // Mostly well-formed frames with random content, plus truncated frames,
    // stray data words and oversize begins. Half way, drain and change the limit.
    task automatic test_random_traffic(input int unsigned n_words, input int unsigned s_pct,
                                       input int unsigned r_pct, input logic [15:0] first_limit);
        int unsigned sent;
        int unsigned kind;
        int unsigned len;
        int unsigned cut;
        bit          paused;
        begin
            send_idle_pct = s_pct;
            recv_idle_pct = r_pct;
            write_limit(first_limit);
            sent   = 0;
            paused = 1'b0;
            while (sent < n_words)
            begin
                if (!paused && sent >= n_words / 2)
                begin
                    write_limit(16'($urandom_range(10, 300)));
                    paused = 1'b1;
                end
                kind = $urandom_range(0, 99);
                if (kind < 72)
                begin
                    len = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 48)
                                                      : $urandom_range(0, 16);
                    send_begin(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 16'(len));
                    sent++;
                    repeat (len)
                    begin
                        send_data(8'($urandom_range(0, 255)));
                        sent++;
                    end
                end
                else if (kind < 82)
                begin
                    len = $urandom_range(2, 20);
                    cut = $urandom_range(0, len - 1);
                    send_begin(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 16'(len));
                    sent++;
                    repeat (cut)
                    begin
                        send_data(8'($urandom_range(0, 255)));
                        sent++;
                    end
                end
                else if (kind < 90)
                begin
                    repeat ($urandom_range(1, 3)) send_data(8'($urandom_range(0, 255)));
                end
                else
                begin
                    len = ($urandom_range(0, 1) == 0) ? $urandom_range(MAX_DATA + 1, 65535)
                                                      : $urandom_range(0, 65535);
                    send_begin(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 16'(len));
                    sent++;
                    repeat ($urandom_range(0, 3)) send_data(8'($urandom_range(0, 255)));
                end
            end
        end
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_zero_and_single_byte();
        test_oversize_lengths();
        test_abandoned_frames();
        test_frame_limit_edges();
        test_longest_frame();

        // Sender idles lightly, receiver heavily; then swap; then no idling at all
        test_random_traffic(20, 27, 77, 16'hFFFF);
        test_random_traffic(20, 77, 27, 16'($urandom_range(10, 60)));
        test_random_traffic(20, 0, 0, 16'($urandom_range(0, 65535)));

        wait_drain();
        if (error_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
